// ===== rtl/pod_pkg.sv =====
// Shared types, opcode codes and decode helpers for the pickle opcode stream delimiter.
// No dependencies; used by pod_walker and the top level.
package pod_pkg;

  localparam int POSITION_BITS_DEF = 36;
  localparam int LEN_W = 36;
  localparam logic [LEN_W-1:0] LIMIT_RESET = 36'd536870912;
  localparam int MIN_LENGTH = 10;
  localparam logic [7:0] MAX_PROTOCOL = 8'h05;

  localparam logic [7:0] OP_STOP      = 8'h2E;
  localparam logic [7:0] OP_NEWLINE   = 8'h0A;
  localparam logic [7:0] OP_PROTO     = 8'h80;
  localparam logic [7:0] OP_FRAME     = 8'h95;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_PROTO_VER  = 9'b000000010,
    PH_OPCODE     = 9'b000000100,
    PH_ARG_PROTO  = 9'b000001000,
    PH_LEN        = 9'b000010000,
    PH_SKIP       = 9'b000100000,
    PH_LINE       = 9'b001000000,
    PH_FRAME_LEN  = 9'b010000000,
    PH_FRAME_BODY = 9'b100000000
  } phase_t;

  typedef enum logic [3:0] {
    OC_STOP, OC_PROTO, OC_LEN, OC_SKIP2, OC_SKIP3, OC_SKIP5, OC_SKIP9,
    OC_LINE1, OC_LINE2, OC_MEMO, OC_FRAME, OC_PLAIN, OC_BAD
  } op_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       source_end;
  } item_t;

  typedef struct packed {
    logic             ok;
    logic [LEN_W-1:0] len;
  } verdict_t;

  function automatic op_class_t classify(input logic [7:0] op);
    op_class_t c;
    case (op)
      8'h2E: c = OC_STOP;
      8'h80: c = OC_PROTO;
      8'h4A, 8'h54, 8'h58, 8'h8F, 8'h5A, 8'h8D, 8'h96, 8'h43, 8'h8E: c = OC_LEN;
      8'h4B, 8'h55, 8'h68, 8'h71: c = OC_SKIP2;
      8'h4D: c = OC_SKIP3;
      8'h72, 8'h6A: c = OC_SKIP5;
      8'h47: c = OC_SKIP9;
      8'h49, 8'h4C, 8'h53, 8'h56, 8'h50, 8'h69: c = OC_LINE1;
      8'h63: c = OC_LINE2;
      8'h70, 8'h67: c = OC_MEMO;
      8'h95: c = OC_FRAME;
      8'h28, 8'h30, 8'h31, 8'h32, 8'h4E, 8'h52, 8'h61, 8'h62, 8'h64, 8'h65,
      8'h6C, 8'h6F, 8'h73, 8'h74, 8'h75, 8'h29, 8'h5D, 8'h7D, 8'h5B, 8'h85,
      8'h86, 8'h87, 8'h88, 8'h89, 8'h93, 8'h94: c = OC_PLAIN;
      default: c = OC_BAD;
    endcase
    return c;
  endfunction

  // length-prefix byte count; table kept as listed
  function automatic logic [3:0] len_bytes(input logic [7:0] op);
    logic [3:0] n;
    if (op == 8'h43 || op == 8'h8E) n = 4'd1;
    else if (op == 8'h5A || op == 8'h8D || op == 8'h96 || op == OP_FRAME) n = 4'd8;
    else n = 4'd4;
    return n;
  endfunction

endpackage

// ===== rtl/pod_walker.sv =====
// Walk state and next-state logic: one byte of a candidate per step.
// Depends on pod_pkg.
module pod_walker #(
  parameter int POSITION_BITS = pod_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  pod_pkg::item_t                item,
  input  logic [pod_pkg::LEN_W-1:0]     limit,
  output logic                          res_valid,
  output pod_pkg::verdict_t             res
);

  localparam int P  = POSITION_BITS;
  localparam int LW = pod_pkg::LEN_W;
  localparam int CW = ((P > LW) ? P : LW) + 2;

  pod_pkg::phase_t phase, phase_next;
  logic [P-1:0]    pos, pos_next;
  logic [7:0]      opcode, opcode_next;
  logic [LW-1:0]   acc_lo, acc_lo_next;
  logic            acc_hi, acc_hi_next;
  logic [2:0]      idx, idx_next;
  logic [LW-1:0]   skip, skip_next;
  logic [P-1:0]    fe, fe_next;
  logic            text, text_next;
  logic [1:0]      lines, lines_next;
  logic            decided, decided_next;

  logic [7:0]      b;
  logic [CW-1:0]   lim, r_w, rp1, dq, dqk, npl, fe_w;
  logic            dtext;
  pod_pkg::op_class_t cls;
  logic [3:0]      k;
  logic            give, ok;
  logic [LW-1:0]   glen;
  logic            do_disp;
  logic [63:0]     sh;
  logic [LW-1:0]   lo_new;
  logic            hi_new;
  logic [3:0]      need;
  logic [1:0]      lines_dec;
  logic            at_end;

  assign b     = item.data_byte;
  assign lim   = CW'(limit);
  assign r_w   = CW'(pos);
  assign rp1   = r_w + CW'(1);
  assign fe_w  = CW'(fe);
  assign dq    = item.first_byte ? '0 : r_w;
  assign dtext = item.first_byte ? 1'b1 : text;
  assign cls   = pod_pkg::classify(b);

  always_comb begin
    unique case (cls)
      pod_pkg::OC_PROTO, pod_pkg::OC_SKIP2: k = 4'd2;
      pod_pkg::OC_SKIP3:                    k = 4'd3;
      pod_pkg::OC_SKIP5:                    k = 4'd5;
      pod_pkg::OC_SKIP9, pod_pkg::OC_FRAME: k = 4'd9;
      default:                              k = 4'd1;
    endcase
  end

  assign dqk = dq + CW'(k);

  // length accumulator: low bits kept, anything at or above bit LW folds into a flag
  assign sh     = 64'(b) << {idx, 3'b000};
  assign lo_new = acc_lo | sh[LW-1:0];
  assign hi_new = acc_hi | (|sh[63:LW]);
  assign npl    = rp1 + CW'(lo_new);
  assign need   = (phase == pod_pkg::PH_FRAME_LEN) ? 4'd8 : pod_pkg::len_bytes(opcode);
  assign lines_dec = (b == pod_pkg::OP_NEWLINE && lines != 2'd0) ? lines - 2'd1 : lines;
  assign at_end = (rp1 == fe_w);

  always_comb begin
    phase_next   = phase;
    pos_next     = pos;
    opcode_next  = opcode;
    acc_lo_next  = acc_lo;
    acc_hi_next  = acc_hi;
    idx_next     = idx;
    skip_next    = skip;
    fe_next      = fe;
    text_next    = text;
    lines_next   = lines;
    decided_next = decided;
    give    = 1'b0;
    ok      = 1'b0;
    glen    = '0;
    do_disp = 1'b0;
    if (step) begin
      if (item.first_byte) begin
        decided_next = 1'b0;
        opcode_next  = '0;
        acc_lo_next  = '0;
        acc_hi_next  = 1'b0;
        idx_next     = '0;
        skip_next    = '0;
        fe_next      = '0;
        lines_next   = '0;
        pos_next     = P'(1);
        if (b == pod_pkg::OP_PROTO) begin
          text_next  = 1'b0;
          phase_next = pod_pkg::PH_PROTO_VER;
        end else begin
          text_next  = 1'b1;
          phase_next = pod_pkg::PH_OPCODE;
          do_disp    = 1'b1;
        end
      end else if (!decided) begin
        pos_next = rp1[P-1:0];
        unique case (phase)
          pod_pkg::PH_PROTO_VER, pod_pkg::PH_ARG_PROTO: begin
            if (b > pod_pkg::MAX_PROTOCOL || rp1 >= lim) give = 1'b1;
            else phase_next = pod_pkg::PH_OPCODE;
          end
          pod_pkg::PH_OPCODE: do_disp = 1'b1;
          pod_pkg::PH_LEN, pod_pkg::PH_FRAME_LEN: begin
            acc_lo_next = lo_new;
            acc_hi_next = hi_new;
            if ({1'b0, idx} + 4'd1 >= need) begin
              if (phase == pod_pkg::PH_FRAME_LEN) begin
                if (rp1 > lim || hi_new || lo_new == '0 || npl > lim) give = 1'b1;
                else begin
                  fe_next    = npl[P-1:0];
                  phase_next = pod_pkg::PH_FRAME_BODY;
                end
              end else if (hi_new || rp1 >= lim || npl >= lim) begin
                give = 1'b1;
              end else if (lo_new == '0) begin
                phase_next = pod_pkg::PH_OPCODE;
              end else begin
                skip_next  = lo_new;
                phase_next = pod_pkg::PH_SKIP;
              end
            end else begin
              idx_next = idx + 3'd1;
            end
          end
          pod_pkg::PH_SKIP: begin
            if (skip <= LW'(1)) begin
              skip_next = '0;
              if (rp1 >= lim) give = 1'b1;
              else phase_next = pod_pkg::PH_OPCODE;
            end else begin
              skip_next = skip - LW'(1);
            end
          end
          pod_pkg::PH_LINE: begin
            lines_next = lines_dec;
            if (rp1 >= lim) give = 1'b1;
            else if (lines_dec == 2'd0) phase_next = pod_pkg::PH_OPCODE;
          end
          pod_pkg::PH_FRAME_BODY: begin
            if (at_end || item.source_end) begin
              if (b == pod_pkg::OP_STOP) begin
                give = 1'b1;
                ok   = 1'b1;
                glen = rp1[LW-1:0];
              end else if (at_end) begin
                // frame closing on the window edge: its last byte is an opcode
                if (fe_w >= lim) do_disp = 1'b1;
                else phase_next = pod_pkg::PH_OPCODE;
              end
            end
          end
          default: give = 1'b1;
        endcase
      end

      if (do_disp) begin
        opcode_next = b;
        if (dq >= lim) give = 1'b1;
        else begin
          unique case (cls)
            pod_pkg::OC_STOP: begin
              give = 1'b1;
              if (dqk >= CW'(pod_pkg::MIN_LENGTH)) begin
                ok   = 1'b1;
                glen = dqk[LW-1:0];
              end
            end
            pod_pkg::OC_PROTO: begin
              if (dqk >= lim) give = 1'b1;
              else phase_next = pod_pkg::PH_ARG_PROTO;
            end
            pod_pkg::OC_LEN, pod_pkg::OC_FRAME: begin
              if (cls == pod_pkg::OC_FRAME && dqk >= lim) give = 1'b1;
              else begin
                acc_lo_next = '0;
                acc_hi_next = 1'b0;
                idx_next    = '0;
                phase_next  = (cls == pod_pkg::OC_FRAME) ? pod_pkg::PH_FRAME_LEN
                                                         : pod_pkg::PH_LEN;
              end
            end
            pod_pkg::OC_SKIP2, pod_pkg::OC_SKIP3, pod_pkg::OC_SKIP5, pod_pkg::OC_SKIP9: begin
              if (dqk >= lim) give = 1'b1;
              else begin
                skip_next  = LW'(k - 4'd1);
                phase_next = pod_pkg::PH_SKIP;
              end
            end
            pod_pkg::OC_LINE1, pod_pkg::OC_LINE2, pod_pkg::OC_MEMO, pod_pkg::OC_PLAIN: begin
              if (dqk >= lim) give = 1'b1;
              else if (cls == pod_pkg::OC_PLAIN || (cls == pod_pkg::OC_MEMO && !dtext)) begin
                phase_next = pod_pkg::PH_OPCODE;
              end else begin
                lines_next = (cls == pod_pkg::OC_LINE2) ? 2'd2 : 2'd1;
                phase_next = pod_pkg::PH_LINE;
              end
            end
            default: give = 1'b1;
          endcase
        end
      end

      // source ran out before a verdict
      if (!give && !decided_next && item.source_end) give = 1'b1;
      if (give) begin
        phase_next   = pod_pkg::PH_IDLE;
        decided_next = 1'b1;
      end
    end
  end

  assign res_valid = step && give;
  assign res.ok    = ok;
  assign res.len   = ok ? glen : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= pod_pkg::PH_IDLE;
      decided <= 1'b1;
      pos     <= '0;
      opcode  <= '0;
      acc_lo  <= '0;
      acc_hi  <= 1'b0;
      idx     <= '0;
      skip    <= '0;
      fe      <= '0;
      text    <= 1'b0;
      lines   <= '0;
    end else begin
      phase   <= phase_next;
      decided <= decided_next;
      pos     <= pos_next;
      opcode  <= opcode_next;
      acc_lo  <= acc_lo_next;
      acc_hi  <= acc_hi_next;
      idx     <= idx_next;
      skip    <= skip_next;
      fe      <= fe_next;
      text    <= text_next;
      lines   <= lines_next;
    end
  end

endmodule

// ===== rtl/pickle_opcode_stream_delimiter_unit.sv =====
// Top level of the pickle opcode stream delimiter: input register, walker, result register.
// Depends on pod_pkg and pod_walker.
//
// The unit takes one byte of a candidate stream per cycle and walks it as pickle opcodes.
// Each candidate (opened by first_byte) ends in at most one result item: accepted with the
// length through STOP, or rejected with a length of zero. A byte is held in the input
// register, and its verdict, if any, is loaded into the result register as the byte
// leaves the input register, which it does only while the result register can take it;
// one byte is taken every cycle as long as the result register drains. Throughput is set
// by the single-pass next-state logic of the walker, which updates all walk state for one
// byte per clock. window_limit is written through its own valid/ready port, always ready,
// and must only change while idle.
module pickle_opcode_stream_delimiter_unit #(
  parameter int POSITION_BITS = pod_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                data_byte,
  input  logic                      first_byte,
  input  logic                      source_end,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      accepted,
  output logic [pod_pkg::LEN_W-1:0] pickle_length,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pod_pkg::LEN_W-1:0] window_limit
);

  logic                      s1_valid;
  pod_pkg::item_t            s1_item;
  logic [pod_pkg::LEN_W-1:0] limit;
  logic                      adv;
  logic                      take;
  logic                      res_valid;
  pod_pkg::verdict_t         res;

  // the held byte moves on whenever the result register can take a verdict
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;
  assign take     = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= pod_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= window_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.data_byte  <= data_byte;
      s1_item.first_byte <= first_byte;
      s1_item.source_end <= source_end;
    end
  end

  pod_walker #(
    .POSITION_BITS(POSITION_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .item      (s1_item),
    .limit     (limit),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register; payload only moves when the slot is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      accepted      <= res.ok;
      pickle_length <= res.len;
    end
  end

endmodule

// ===== rtl/pod_checker.sv =====
// Port-level checks for the delimiter unit, attached by bind.
// Depends on pod_pkg and the top level's port list.
module pod_port_checks (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      accepted,
  input logic [pod_pkg::LEN_W-1:0] pickle_length
);

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> pickle_length == '0)
    else $error("rejected item carries a length");

  a_accept_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> pickle_length >= pod_pkg::LEN_W'(pod_pkg::MIN_LENGTH))
    else $error("accepted item shorter than a pickle stub");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pickle_length) && $stable(accepted))
    else $error("stalled result changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind pickle_opcode_stream_delimiter_unit pod_port_checks u_pod_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .accepted      (accepted),
  .pickle_length (pickle_length)
);

// ===== test/pod_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker for the pickle opcode stream delimiter: watches the byte, result and
// window channels, predicts each verdict and compares. Depends on pod_pkg.
module pod_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [7:0]                data_byte,
  input  logic                      first_byte,
  input  logic                      source_end,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      accepted,
  input  logic [pod_pkg::LEN_W-1:0] pickle_length,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [pod_pkg::LEN_W-1:0] window_limit,
  output int                        errors,
  output int                        pending
);
  import pod_pkg::*;

  localparam logic [63:0] POS_MASK = (64'd1 << POSITION_BITS_DEF) - 64'd1;

  verdict_t    verdicts_due[$];
  logic [63:0] win;
  phase_t      ph;
  logic [63:0] pos, acc, skip_left, frame_end;
  logic [7:0]  op_now;
  int          len_idx, lines;
  bit          text_mode, done, got;
  verdict_t    made;

  function void verdict(bit ok, logic [63:0] n);
    done = 1;
    ph = PH_IDLE;
    got = 1;
    made.ok = ok;
    made.len = ok ? n[LEN_W-1:0] : '0;
  endfunction

  function void resume_at(logic [63:0] np);
    if (np >= win) verdict(0, 0);
    else ph = PH_OPCODE;
  endfunction

  function void skip_from(logic [63:0] q, logic [63:0] n);
    if (q + n >= win) verdict(0, 0);
    else begin
      skip_left = n - 1;
      ph = PH_SKIP;
    end
  endfunction

  function void lines_from(logic [63:0] q, int c);
    if (q + 1 >= win) verdict(0, 0);
    else begin
      lines = c;
      ph = PH_LINE;
    end
  endfunction

  function void open_len(phase_t p);
    acc = 0;
    len_idx = 0;
    ph = p;
  endfunction

  function int prefix_bytes(logic [7:0] op);
    if (op == 8'h43 || op == 8'h8E) return 1;
    if (op == 8'h5A || op == 8'h8D || op == 8'h96 || op == OP_FRAME) return 8;
    return 4;
  endfunction

  function void decode(logic [63:0] q, logic [7:0] op);
    if (q >= win) begin
      verdict(0, 0);
      return;
    end
    op_now = op;
    case (op)
      OP_STOP: if (q + 1 < MIN_LENGTH) verdict(0, 0); else verdict(1, q + 1);
      OP_PROTO: if (q + 2 >= win) verdict(0, 0); else ph = PH_ARG_PROTO;
      8'h4A, 8'h54, 8'h58, 8'h8F, 8'h5A, 8'h8D, 8'h96, 8'h43, 8'h8E: open_len(PH_LEN);
      8'h4B, 8'h55, 8'h68, 8'h71: skip_from(q, 2);
      8'h4D: skip_from(q, 3);
      8'h72, 8'h6A: skip_from(q, 5);
      8'h47: skip_from(q, 9);
      8'h49, 8'h4C, 8'h53, 8'h56, 8'h50, 8'h69: lines_from(q, 1);
      8'h63: lines_from(q, 2);
      8'h70, 8'h67: if (text_mode) lines_from(q, 1); else resume_at(q + 1);
      OP_FRAME: if (q + 9 >= win) verdict(0, 0); else open_len(PH_FRAME_LEN);
      8'h28, 8'h30, 8'h31, 8'h32, 8'h4E, 8'h52, 8'h61, 8'h62, 8'h64, 8'h65, 8'h6C,
      8'h6F, 8'h73, 8'h74, 8'h75, 8'h29, 8'h5D, 8'h7D, 8'h5B, 8'h85, 8'h86, 8'h87,
      8'h88, 8'h89, 8'h93, 8'h94: resume_at(q + 1);
      default: verdict(0, 0);
    endcase
  endfunction

  function void length_known(logic [63:0] r);
    logic [63:0] np;
    np = r + 1;
    if (ph == PH_FRAME_LEN) begin
      if (np > win || acc == 0 || acc > win - np) verdict(0, 0);
      else begin
        frame_end = (np + acc) & POS_MASK;
        ph = PH_FRAME_BODY;
      end
    end else if (acc[63] || np >= win || acc >= win - np) verdict(0, 0);
    else if (acc == 0) ph = PH_OPCODE;
    else begin
      skip_left = acc;
      ph = PH_SKIP;
    end
  endfunction

  function void advance(logic [63:0] r, logic [7:0] b, bit e);
    bit at_end;
    int need;
    case (ph)
      PH_PROTO_VER, PH_ARG_PROTO: if (b > MAX_PROTOCOL) verdict(0, 0); else resume_at(r + 1);
      PH_OPCODE: decode(r, b);
      PH_LEN, PH_FRAME_LEN: begin
        need = (ph == PH_FRAME_LEN) ? 8 : prefix_bytes(op_now);
        acc |= 64'(b) << (8 * (len_idx & 7));
        if (len_idx + 1 >= need) length_known(r);
        else len_idx = (len_idx + 1) & 7;
      end
      PH_SKIP: begin
        if (skip_left <= 1) begin
          skip_left = 0;
          resume_at(r + 1);
        end else skip_left -= 1;
      end
      PH_LINE: begin
        if (b == OP_NEWLINE && lines > 0) lines -= 1;
        if (r + 1 >= win) verdict(0, 0);
        else if (lines == 0) ph = PH_OPCODE;
      end
      PH_FRAME_BODY: begin
        at_end = (r + 1 == frame_end);
        if (at_end || e) begin
          if (b == OP_STOP) verdict(1, r + 1);
          else if (at_end) begin
            if (frame_end >= win) decode(r, b);
            else ph = PH_OPCODE;
          end
        end
      end
      default: verdict(0, 0);
    endcase
  endfunction

  function void take_byte(logic [7:0] b, bit f, bit e);
    logic [63:0] r;
    got = 0;
    if (f) begin
      done = 0;
      op_now = 0;
      acc = 0;
      len_idx = 0;
      skip_left = 0;
      frame_end = 0;
      lines = 0;
      pos = 1;
      if (b == OP_PROTO) begin
        text_mode = 0;
        ph = PH_PROTO_VER;
      end else begin
        text_mode = 1;
        ph = PH_OPCODE;
        decode(0, b);
      end
    end else begin
      if (done) return;
      r = pos;
      pos = (r + 1) & POS_MASK;
      advance(r, b, e);
    end
    if (!got && !done && e) verdict(0, 0);
    if (got) verdicts_due = {verdicts_due, made};
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      win = 64'(LIMIT_RESET);
      ph = PH_IDLE;
      pos = 0;
      op_now = 0;
      acc = 0;
      len_idx = 0;
      skip_left = 0;
      frame_end = 0;
      text_mode = 0;
      lines = 0;
      done = 1;
      verdicts_due.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) win = 64'(window_limit);
      if (in_valid && !in_stall) take_byte(data_byte, first_byte, source_end);
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result accepted=%0b length=%0d", $time, accepted,
                   pickle_length);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (accepted !== want.ok || pickle_length !== want.len) begin
            $display("%0t: verdict mismatch expected %0b/%0d actual %0b/%0d", $time,
                     want.ok, want.len, accepted, pickle_length);
            errors++;
          end
        end
      end
      pending = verdicts_due.size();
    end
  end
endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the pickle opcode stream delimiter unit.
// Depends on pod_pkg, pod_checker and the unit itself.
module tb;
  import pod_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [LEN_W-1:0] WIN_MAX = '1;

  logic             clk = 0;
  logic             rst = 1;
  logic             in_valid = 0;
  logic             in_stall;
  logic [7:0]       data_byte = '0;
  logic             first_byte = 0;
  logic             source_end = 0;
  logic             out_valid;
  logic             out_stall = 0;
  logic             accepted;
  logic [LEN_W-1:0] pickle_length;
  logic             cfg_valid = 0;
  logic             cfg_ready;
  logic [LEN_W-1:0] window_limit = LIMIT_RESET;
  int               errors, pending;

  int               idle_pct = 0;   // sender gap chance, per cent
  int               stall_pct = 0;  // receiver stall chance, per cent
  int               quiet = 0;      // cycles since anything moved
  logic [7:0]       stream[$];      // bytes of the candidate being built

  // plain one-byte opcodes, valid in either mode
  logic [7:0] plain_ops[26] = '{8'h28, 8'h30, 8'h31, 8'h32, 8'h4E, 8'h52, 8'h61, 8'h62,
    8'h64, 8'h65, 8'h6C, 8'h6F, 8'h73, 8'h74, 8'h75, 8'h29, 8'h5D, 8'h7D, 8'h5B, 8'h85,
    8'h86, 8'h87, 8'h88, 8'h89, 8'h93, 8'h94};

  pickle_opcode_stream_delimiter_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .first_byte, .source_end,
    .out_valid, .out_stall, .accepted, .pickle_length,
    .cfg_valid, .cfg_ready, .window_limit
  );

  pod_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .first_byte, .source_end,
    .out_valid, .out_stall, .accepted, .pickle_length,
    .cfg_valid, .cfg_ready, .window_limit, .errors, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: any accepted item on either side clears the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= STALL_LIMIT);
    $display("tb: errors");
    $finish;
  end

  task automatic send(logic [7:0] b, bit f, bit e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    data_byte <= b;
    first_byte <= f;
    source_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // pushes the candidate in stream; source end on the last byte if asked, else rarely
  task automatic send_stream(bit end_last);
    for (int i = 0; i < stream.size(); i++)
      send(stream[i], i == 0,
           (end_last && i == stream.size() - 1) || ($urandom_range(79) == 0));
  endtask

  // hold the sender until every verdict is in, then allow the pipe to settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_window(logic [LEN_W-1:0] w);
    drain();
    cfg_valid <= 1;
    window_limit <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // appends one byte to the candidate being built
  task automatic add_byte(logic [7:0] v);
    stream = {stream, v};
  endtask

  task automatic push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic push_line();
    repeat ($urandom_range(4)) add_byte(8'($urandom_range(8'h7E, 8'h20)));
    add_byte(OP_NEWLINE);
  endtask

  // one opcode, mostly with a well-formed operand
  task automatic push_opcode(bit binary);
    logic [63:0] n;
    logic [7:0]  op;
    case ($urandom_range(11))
      0, 1: add_byte(plain_ops[$urandom_range(25)]);
      2: begin
        op = $urandom_range(1) ? 8'h43 : 8'h8E;
        n = $urandom_range(5);
        add_byte(op);
        push_le(n, 1);
        repeat (n) add_byte(8'($urandom));
      end
      3: begin
        case ($urandom_range(3))
          0: op = 8'h4A; 1: op = 8'h54; 2: op = 8'h58; default: op = 8'h8F;
        endcase
        n = $urandom_range(5);
        add_byte(op);
        push_le(n, 4);
        repeat (n) add_byte(8'($urandom));
      end
      4: begin
        case ($urandom_range(2))
          0: op = 8'h5A; 1: op = 8'h8D; default: op = 8'h96;
        endcase
        // a length with the top bit set must be refused
        n = ($urandom_range(15) == 0) ? {1'b1, 63'($urandom)} : 64'($urandom_range(4));
        add_byte(op);
        push_le(n, 8);
        if (!n[63]) repeat (n) add_byte(8'($urandom));
      end
      5: begin
        case ($urandom_range(6))
          0: begin add_byte(8'h4B); n = 2; end
          1: begin add_byte(8'h71); n = 2; end
          2: begin add_byte(8'h4D); n = 3; end
          3: begin add_byte(8'h72); n = 5; end
          4: begin add_byte(8'h6A); n = 5; end
          5: begin add_byte(8'h47); n = 9; end
          default: begin add_byte(8'h68); n = 2; end
        endcase
        repeat (n) add_byte(8'($urandom));
      end
      6: begin
        case ($urandom_range(5))
          0: add_byte(8'h49); 1: add_byte(8'h4C);
          2: add_byte(8'h53); 3: add_byte(8'h56);
          4: add_byte(8'h50); default: add_byte(8'h69);
        endcase
        push_line();
      end
      7: begin
        add_byte(8'h63);
        push_line();
        push_line();
      end
      8: begin
        // memo ops read a line in text mode only
        add_byte($urandom_range(1) ? 8'h70 : 8'h67);
        if (!binary) push_line();
      end
      9: begin
        // frame body of plain ops, sometimes closed by STOP
        n = $urandom_range(10, 1);
        add_byte(OP_FRAME);
        push_le(n, 8);
        for (int i = 0; i < n; i++)
          add_byte((i == n - 1 && $urandom_range(2) == 0) ? OP_STOP
                                                           : plain_ops[$urandom_range(25)]);
      end
      10: begin
        add_byte(OP_PROTO);
        add_byte(($urandom_range(9) == 0) ? 8'($urandom_range(255, 6))
                                          : 8'($urandom_range(5)));
      end
      default: add_byte(($urandom_range(3) == 0) ? 8'($urandom)
                                                 : plain_ops[$urandom_range(25)]);
    endcase
  endtask

  task automatic make_pickle(bit binary, int nops, bit stop_end);
    stream.delete();
    if (binary) begin
      add_byte(OP_PROTO);
      add_byte(($urandom_range(19) == 0) ? 8'($urandom_range(255, 6))
                                         : 8'($urandom_range(5)));
    end
    repeat (nops) push_opcode(binary);
    if (stop_end) begin
      while (stream.size() < 9 && $urandom_range(7) != 0)
        add_byte(plain_ops[$urandom_range(25)]);
      add_byte(OP_STOP);
    end
  endtask

  task automatic make_noise();
    stream.delete();
    repeat ($urandom_range(20, 1)) add_byte(8'($urandom));
  endtask

  // a mix of well-formed pickles, broken ones and stray bytes
  task automatic random_run(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: make_noise();
        1: make_pickle($urandom_range(1), $urandom_range(6), 0);
        default: make_pickle($urandom_range(1), $urandom_range(8, 1), 1);
      endcase
      send_stream($urandom_range(7) == 0);
      sent += stream.size();
      // bytes after a verdict are ignored by the unit
      if ($urandom_range(5) == 0) begin
        send(8'($urandom), 0, $urandom_range(1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: short STOP, text pickle with lines, binary with frame STOP, bad
    // protocol, unknown opcode, source ending first, stray bytes before any candidate
    send(8'hFF, 0, 0);
    stream = '{OP_STOP};
    send_stream(0);
    stream = '{8'h28, 8'h49, 8'h31, OP_NEWLINE, 8'h63, 8'h61, OP_NEWLINE, 8'h62, OP_NEWLINE,
               8'h70, 8'h30, OP_NEWLINE, 8'h67, 8'h30, OP_NEWLINE, OP_STOP};
    send_stream(0);
    stream = '{OP_PROTO, MAX_PROTOCOL, OP_FRAME, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h00, 8'h29, 8'h5D, OP_STOP};
    send_stream(0);
    stream = '{OP_PROTO, 8'h06};
    send_stream(0);
    stream = '{8'h00, 8'h28};
    send_stream(0);
    stream = '{8'h28, 8'h29, 8'h30};
    send_stream(1);

    random_run(120);
    set_window(20);
    idle_pct = 82;
    random_run(110);
    set_window(1);
    idle_pct = 0;
    stall_pct = 82;
    random_run(70);
    set_window(WIN_MAX);
    idle_pct = 27;
    stall_pct = 27;
    random_run(130);
    set_window(12);
    idle_pct = 0;
    stall_pct = 0;
    random_run(110);
    set_window(LIMIT_RESET);
    idle_pct = 82;
    stall_pct = 82;
    random_run(90);
    set_window(40);
    idle_pct = 27;
    stall_pct = 27;
    random_run(100);

    drain();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
